// ----- rtl/core/ehp_pkg.sv -----
package ehp_pkg;

  localparam int unsigned MAX_ROWS    = 4096;
  localparam int unsigned MAX_ROW_LEN = 256;
  localparam int unsigned HIDX_W      = $clog2(MAX_ROWS);
  localparam int unsigned LOG2_MAX    = 6;

  localparam int unsigned CFG_W     = 13;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned IN_DATA_W  = 128;
  localparam int unsigned OUT_DATA_W = 176;

  localparam logic [CFG_IDX_W-1:0] CFG_HACK_LOG2  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_COUNT = 1'd1;

  localparam logic [2:0]  HACK_LOG2_RESET = 3'd5;
  localparam logic [2:0]  HACK_LOG2_CAP   = 3'(LOG2_MAX);
  localparam logic [12:0] ROWS_CAP        = 13'(MAX_ROWS);
  localparam logic [8:0]  LEN_CAP         = 9'(MAX_ROW_LEN);
  localparam logic [21:0] SAT21           = 22'h1F_FFFF;

  localparam logic KIND_HACK  = 1'b0;
  localparam logic KIND_PLACE = 1'b1;
  localparam logic FUNC_ROW_LEN = 1'b0;

  typedef struct packed {
    logic row_step;
    logic look;
    logic place;
  } ehp_cmd_t;

  typedef struct packed {
    logic out_free;
  } ehp_sts_t;

endpackage

// ----- rtl/core/ehp_ctrl.sv -----
module ehp_ctrl
  import ehp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_func_i,
  input  ehp_sts_t sts_i,
  output logic     in_ready_o,
  output ehp_cmd_t cmd_o
);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_PLACE = 1'b1;

  logic state_q, state_d;
  logic take;

  assign in_ready_o = (state_q == ST_IDLE) && sts_i.out_free;
  assign take       = in_ready_o && in_valid_i;

  assign cmd_o.row_step = take && (in_func_i == FUNC_ROW_LEN);
  assign cmd_o.look     = take && (in_func_i != FUNC_ROW_LEN);
  assign cmd_o.place    = (state_q == ST_PLACE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.look) state_d = ST_PLACE;
      end
      ST_PLACE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_look_then_place: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.look |=> cmd_o.place && !in_ready_o)
    else $error("lookup not followed by placement");

  a_place_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.place |=> !cmd_o.place)
    else $error("placement held longer than one cycle");

endmodule

// ----- rtl/core/ehp_datapath.sv -----
module ehp_datapath
  import ehp_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_data_i,
  input  ehp_cmd_t               cmd_i,
  output ehp_sts_t               sts_o,
  input  logic [IN_DATA_W-1:0]   in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [OUT_DATA_W-1:0]  out_data_o,
  output logic                   out_kind_o,
  output logic                   out_last_o
);

  logic [2:0]  hack_log2_q;
  logic [12:0] rows_q;

  logic [12:0] row_cnt_q;
  logic [8:0]  hack_max_q;
  logic [20:0] offset_q;
  logic [20:0] height_q;

  logic [20:0] mem [MAX_ROWS];
  logic [20:0] rd_q;

  logic [5:0]  lane_q;
  logic [7:0]  slot_q;
  logic [63:0] value_q;
  logic [30:0] col_q;

  logic        out_valid_q;
  logic        kind_q;
  logic        last_q;
  logic [11:0] ohidx_q;
  logic [20:0] ostart_q;
  logic [20:0] oalloc_q;
  logic [19:0] odest_q;
  logic [63:0] oval_q;
  logic [30:0] ocol_q;

  logic [8:0]  in_row_len;
  logic [11:0] in_row;
  logic [7:0]  in_slot;
  logic [63:0] in_value;
  logic [30:0] in_col;

  logic [2:0]  lg;
  logic [5:0]  lane_mask;
  logic [12:0] nrows;
  logic [8:0]  len;
  logic [5:0]  lane;
  logic [8:0]  base_max;
  logic [8:0]  new_max;
  logic        active;
  logic        last;
  logic        close;
  logic [HIDX_W-1:0] wr_idx;
  logic [HIDX_W-1:0] rd_idx;
  logic [21:0] height_sum;
  logic [21:0] offset_sum;
  logic [20:0] height_d;
  logic [20:0] offset_d;
  logic [19:0] dest;

  assign in_row_len = in_data_i[8:0];
  assign in_row     = in_data_i[20:9];
  assign in_slot    = in_data_i[28:21];
  assign in_value   = in_data_i[92:29];
  assign in_col     = in_data_i[123:93];

  assign lg        = (hack_log2_q > HACK_LOG2_CAP) ? HACK_LOG2_CAP : hack_log2_q;
  assign lane_mask = 6'((7'd1 << lg) - 7'd1);
  assign nrows     = (rows_q > ROWS_CAP) ? ROWS_CAP : rows_q;
  assign len       = (in_row_len > LEN_CAP) ? LEN_CAP : in_row_len;
  assign lane      = row_cnt_q[5:0] & lane_mask;
  assign base_max  = (lane == 6'd0) ? 9'd0 : hack_max_q;
  assign new_max   = (len > base_max) ? len : base_max;
  assign active    = row_cnt_q < nrows;
  assign last      = ({1'b0, row_cnt_q} + 14'd1) == {1'b0, nrows};
  assign close     = active && ((lane == lane_mask) || last);
  assign wr_idx    = HIDX_W'(row_cnt_q >> lg);
  assign rd_idx    = HIDX_W'(in_row >> lg);

  assign height_sum = {1'b0, height_q} + 22'(new_max);
  assign offset_sum = {1'b0, offset_q} + (22'(new_max) << lg);
  assign height_d   = (height_sum > SAT21) ? 21'h1F_FFFF : height_sum[20:0];
  assign offset_d   = (offset_sum > SAT21) ? 21'h1F_FFFF : offset_sum[20:0];

  assign dest = 20'(rd_q) + 20'(lane_q) + 20'(14'(slot_q) << lg);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hack_log2_q <= HACK_LOG2_RESET;
      rows_q      <= 13'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HACK_LOG2:  hack_log2_q <= cfg_data_i[2:0];
        CFG_ROWS_COUNT: rows_q      <= cfg_data_i[12:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q  <= 13'd0;
      hack_max_q <= 9'd0;
      offset_q   <= 21'd0;
      height_q   <= 21'd0;
    end else if (cmd_i.row_step && active) begin
      row_cnt_q  <= row_cnt_q + 13'd1;
      hack_max_q <= new_max;
      if (close) begin
        offset_q <= offset_d;
        height_q <= height_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.row_step && close) mem[wr_idx] <= offset_q;
    if (cmd_i.look) rd_q <= mem[rd_idx];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.look) begin
      lane_q  <= in_row[5:0] & lane_mask;
      slot_q  <= in_slot;
      value_q <= in_value;
      col_q   <= in_col;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((cmd_i.row_step && close) || cmd_i.place) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.row_step && close) begin
      kind_q   <= KIND_HACK;
      ohidx_q  <= 12'(wr_idx);
      ostart_q <= offset_q;
      oalloc_q <= height_d;
      last_q   <= last;
      odest_q  <= 20'd0;
      oval_q   <= 64'd0;
      ocol_q   <= 31'd0;
    end else if (cmd_i.place) begin
      kind_q   <= KIND_PLACE;
      ohidx_q  <= 12'd0;
      ostart_q <= 21'd0;
      oalloc_q <= 21'd0;
      last_q   <= 1'b0;
      odest_q  <= dest;
      oval_q   <= value_q;
      ocol_q   <= col_q;
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_kind_o     = kind_q;
  assign out_last_o     = last_q;
  assign out_data_o     = {7'd0, ocol_q, oval_q, odest_q, oalloc_q, ostart_q, ohidx_q};

  a_place_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.place |-> !out_valid_q)
    else $error("placement result would overwrite a pending word");

  a_row_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_cnt_q <= ROWS_CAP)
    else $error("row counter beyond table depth");

  a_close_reports: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.row_step && close) |=> out_valid_q && (kind_q == KIND_HACK))
    else $error("closed hack not reported");

endmodule

// ----- rtl/core/ell_to_hacked_ell_placer_core.sv -----
// Converts ELLPACK to hacked ELLPACK placement. Row-length words (tuser 0) arrive in row
// order; each word that closes a hack (its last lane or the last row in use) yields one
// report word and stores the hack start in a 4096 x 21 table. Element words (tuser 1)
// read that table; the registered table read feeds a placement step that loads the
// destination index into the output register. Input is held off during that placement
// step. A word is accepted whenever no placement is under way and the output register
// is empty or being drained in that cycle.
// Element words must only name hacks already closed; the table has no reset.
module ell_to_hacked_ell_placer_core
  import ehp_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_data_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // row_len[8:0], row[20:9], slot[28:21], value[92:29], col_index[123:93]
  input  logic [IN_DATA_W-1:0]   s_axis_tdata,
  // func[0]
  input  logic                   s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // hack_index[11:0], hack_start[32:12], alloc_height[53:33], dest_index[73:54],
  // out_value[137:74], out_col_index[168:138]
  output logic [OUT_DATA_W-1:0]  m_axis_tdata,
  // kind[0]
  output logic                   m_axis_tuser,
  output logic                   m_axis_tlast
);

  ehp_cmd_t cmd;
  ehp_sts_t sts;

  ehp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_func_i  (s_axis_tuser),
    .sts_i      (sts),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  ehp_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_kind_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule
